[hdl/rfwe_pkg.sv]
// ----------------------------------------------------------------------------
// rfwe_pkg
// Shared types, constants and codes for the rigid fit weighted error block.
// ----------------------------------------------------------------------------
package rfwe_pkg;

  localparam int MAX_PAIRS = 1024;
  localparam int CNT_W = 11;
  localparam int NUM_REGS = 7;
  localparam int NUM_QP = 10;
  localparam int NUM_MAT = 9;
  localparam int DIV_M_STEPS = 31;
  localparam int DIV_MEAN_STEPS = 32;
  localparam int SQRT_STEPS = 31;

  localparam logic [2:0] REG_QA = 3'd0;
  localparam logic [2:0] REG_QB = 3'd1;
  localparam logic [2:0] REG_QC = 3'd2;
  localparam logic [2:0] REG_QD = 3'd3;
  localparam logic [2:0] REG_SX = 3'd4;
  localparam logic [2:0] REG_SY = 3'd5;
  localparam logic [2:0] REG_SZ = 3'd6;

  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000
  };

  // Operand pairs of the quaternion products: aa bb cc dd ab ac ad bc bd cd.
  localparam logic [1:0] QP_LEFT [NUM_QP] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2
  };
  localparam logic [1:0] QP_RIGHT [NUM_QP] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
  };

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_QUAT = 2'd1,
    ST_FEW_PAIRS = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    logic signed [23:0] ref_z;
    logic signed [23:0] moved_x;
    logic signed [23:0] moved_y;
    logic signed [23:0] moved_z;
    logic [15:0]        weight;
    logic               last_pair;
  } pair_word_t;

  typedef struct packed {
    logic [31:0] mean_error;
    status_t     status;
  } result_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_QMUL, OP_QSTORE, OP_LATCH, OP_MCLEAR,
    OP_DIV_LOAD_M, OP_DIV_STEP, OP_MSTORE, OP_ROW_INIT, OP_MV_MUL,
    OP_MV_ACC, OP_RND, OP_SQ, OP_SS, OP_SQRT_LOAD, OP_SQRT_STEP,
    OP_SQRT_FIN, OP_WMUL, OP_ACCUM, OP_COUNT, OP_MEAN_PREP,
    OP_DIV_LOAD_MEAN, OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
    logic [1:0] row;
    logic [1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic accum_ok;
    logic last;
    logic n_zero;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_QMUL, S_QSTORE, S_LATCH, S_MCLEAR, S_DLOAD, S_DSTEP,
    S_MSTORE, S_ROW_INIT, S_MV_MUL, S_MV_ACC, S_RND, S_SQ, S_SS,
    S_SQRT_LOAD, S_SQRT_STEP, S_SQRT_FIN, S_WMUL, S_ACCUM, S_COUNT,
    S_MEAN_PREP, S_MLOAD, S_MSTEP, S_DONE
  } ctrl_state_t;

endpackage

[hdl/rigid_fit_weighted_error.sv]
// ----------------------------------------------------------------------------
// rigid_fit_weighted_error
// Weighted mean distance of matched point pairs under a quaternion rigid
// transform, with a sequencer driving a shared fixed-point datapath.
// ----------------------------------------------------------------------------
// An ordinary pair word computes its weighted distance; one past the pair
// limit is only counted. The first pair of a run adds ten quaternion products
// and nine 31-step divisions for the rotation matrix (a matrix clear instead
// with a zero quaternion). A last pair adds the 32-step division for the mean.
// One word is in work at a time; the result register frees the output side.
// Reset is synchronous; it restores the pose registers and clears the run.
// ----------------------------------------------------------------------------
module rigid_fit_weighted_error (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pair_valid,
  output logic                   pair_stall,
  input  rfwe_pkg::pair_word_t   pair_word,
  output logic                   result_valid,
  input  logic                   result_stall,
  output rfwe_pkg::result_word_t result_word,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import rfwe_pkg::*;

  // Commands flow from the sequencer; status flags come back from the
  // datapath. The sequencer takes a word only while it sits idle.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rfwe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the pose registers, the latched transform, the run
  // sums and the result register that parts the output side.
  rfwe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pair_word    (pair_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

[hdl/rfwe_dp.sv]
// ----------------------------------------------------------------------------
// rfwe_dp
// Datapath: pose registers, transform store, two multipliers, a shared
// restoring divider, a bit-serial square root and the run accumulators.
// ----------------------------------------------------------------------------
module rfwe_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  rfwe_pkg::dp_cmd_t      cmd,
  output rfwe_pkg::dp_stat_t     stat,
  input  rfwe_pkg::pair_word_t   pair_word,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output rfwe_pkg::result_word_t result_word
);
  import rfwe_pkg::*;

  logic [15:0]        cfg_reg [NUM_REGS];
  logic signed [16:0] qv [4];
  logic signed [33:0] qp [NUM_QP];
  logic signed [31:0] mat [NUM_MAT];
  logic signed [22:0] trans [3];
  logic               qzero;
  pair_word_t         pw;

  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod_a;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;
  logic [63:0]        prod_b;

  logic signed [57:0] acc;
  logic [29:0]        dm;
  logic [61:0]        ss;
  logic [61:0]        sr;
  logic [34:0]        sq_r;
  logic [30:0]        sq_q;
  logic [31:0]        root;
  logic [63:0]        sum;
  logic [CNT_W-1:0]   count;
  logic [44:0]        nq;
  status_t            status_r;
  logic               sat;

  logic [33:0]        drem;
  logic [31:0]        dq;
  logic [32:0]        ddiv;

  logic signed [35:0] n_val;
  logic signed [35:0] m_sel;
  logic [35:0]        m_mag;
  logic [62:0]        dvd;
  logic signed [22:0] ref_sel;
  logic signed [23:0] mv_sel;
  logic signed [22:0] t_sel;
  logic [57:0]        acc_mag;
  logic [57:0]        rnd_sum;
  logic [34:0]        rp;
  logic [34:0]        trial;
  logic               sq_ge;
  logic [33:0]        dt;
  logic               d_ge;
  logic [64:0]        nsum;
  logic [30:0]        quo;

  for (genvar k = 0; k < 4; k++) begin : g_q
    assign qv[k] = $signed({1'b0, cfg_reg[k]} - 17'd32768);
  end

  // Rotation numerators, scaled by the squared norm.
  always_comb begin
    n_val = 36'(qp[0]) + 36'(qp[1]) + 36'(qp[2]) + 36'(qp[3]);
    case (cmd.idx)
      4'd0:    m_sel = 36'(qp[0]) + 36'(qp[1]) - 36'(qp[2]) - 36'(qp[3]);
      4'd1:    m_sel = (36'(qp[7]) - 36'(qp[6])) <<< 1;
      4'd2:    m_sel = (36'(qp[8]) + 36'(qp[5])) <<< 1;
      4'd3:    m_sel = (36'(qp[7]) + 36'(qp[6])) <<< 1;
      4'd4:    m_sel = 36'(qp[0]) - 36'(qp[1]) + 36'(qp[2]) - 36'(qp[3]);
      4'd5:    m_sel = (36'(qp[9]) - 36'(qp[4])) <<< 1;
      4'd6:    m_sel = (36'(qp[8]) - 36'(qp[5])) <<< 1;
      4'd7:    m_sel = (36'(qp[9]) + 36'(qp[4])) <<< 1;
      4'd8:    m_sel = 36'(qp[0]) - 36'(qp[1]) - 36'(qp[2]) + 36'(qp[3]);
      default: m_sel = '0;
    endcase
    m_mag = m_sel[35] ? 36'(-m_sel) : 36'(m_sel);
    dvd = {m_mag[32:0], 30'd0} + 63'(n_val[32:1]);
  end

  always_comb begin
    case (cmd.row)
      2'd0:    ref_sel = 23'(0);
      default: ref_sel = 23'(0);
    endcase
    case (cmd.row)
      2'd1:    t_sel = trans[1];
      2'd2:    t_sel = trans[2];
      default: t_sel = trans[0];
    endcase
    case (cmd.col)
      2'd1:    mv_sel = pw.moved_y;
      2'd2:    mv_sel = pw.moved_z;
      default: mv_sel = pw.moved_x;
    endcase
  end

  logic signed [23:0] ref_pt;
  always_comb begin
    case (cmd.row)
      2'd1:    ref_pt = pw.ref_y;
      2'd2:    ref_pt = pw.ref_z;
      default: ref_pt = pw.ref_x;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_x = '0;
    mul_y = '0;
    case (cmd.op)
      OP_QMUL: begin
        mul_a = 32'(qv[QP_LEFT[cmd.idx]]);
        mul_b = 24'(qv[QP_RIGHT[cmd.idx]]);
      end
      OP_MV_MUL: begin
        mul_a = mat[cmd.idx];
        mul_b = mv_sel;
      end
      OP_SQ: begin
        mul_x = {2'b00, dm};
        mul_y = {2'b00, dm};
      end
      OP_WMUL: begin
        mul_x = root;
        mul_y = {16'd0, pw.weight};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    acc_mag = acc[57] ? 58'(-acc) : 58'(acc);
    rnd_sum = acc_mag + (58'd1 << 25);
    rp = {sq_r[32:0], sr[61:60]};
    trial = {2'b00, sq_q, 2'b01};
    sq_ge = rp >= trial;
    dt = {drem[32:0], dq[31]};
    d_ge = dt >= {1'b0, ddiv};
    nsum = {1'b0, sum} + (65'(count) << 19);
    quo = dq[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        cfg_reg[k] <= REG_RESET[k];
      end
    end else if (cfg_write && (cfg_index < 3'(NUM_REGS))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      count <= '0;
      qzero <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT_LOAD) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LATCH:  qzero <= (n_val == 36'sd0);
        OP_ACCUM:  sum <= sum + prod_b;
        OP_COUNT: begin
          if (count <= CNT_W'(MAX_PAIRS)) begin
            count <= count + 1'b1;
          end
        end
        OP_OUT_LOAD: begin
          sum <= '0;
          count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_a <= mul_a * mul_b;
    prod_b <= mul_x * mul_y;
    case (cmd.op)
      OP_CAPTURE: begin
        pw <= pair_word;
        ss <= '0;
      end
      OP_QSTORE: qp[cmd.idx] <= prod_a[33:0];
      OP_LATCH: begin
        for (int k = 0; k < 3; k++) begin
          trans[k] <= (23'($signed({1'b0, cfg_reg[4 + k]} - 17'd32768)) <<< 5)
                    + (23'($signed({1'b0, cfg_reg[4 + k]} - 17'd32768)) <<< 3);
        end
      end
      OP_MCLEAR: begin
        for (int k = 0; k < NUM_MAT; k++) begin
          mat[k] <= '0;
        end
      end
      OP_DIV_LOAD_M: begin
        drem <= 34'(dvd[62:31]);
        dq <= {dvd[30:0], 1'b0};
        ddiv <= n_val[32:0];
      end
      OP_DIV_STEP: begin
        drem <= d_ge ? (dt - {1'b0, ddiv}) : dt;
        dq <= {dq[30:0], d_ge};
      end
      OP_MSTORE: begin
        mat[cmd.idx] <= m_sel[35] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      OP_ROW_INIT: acc <= (58'(t_sel) <<< 22) - (58'(ref_pt) <<< 30)
                        + 58'(ref_sel);
      OP_MV_ACC:   acc <= acc + 58'(prod_a);
      OP_RND:      dm <= rnd_sum[55:26];
      OP_SS:       ss <= ss + prod_b[61:0];
      OP_SQRT_LOAD: begin
        sr <= ss;
        sq_r <= '0;
        sq_q <= '0;
      end
      OP_SQRT_STEP: begin
        sq_r <= sq_ge ? (rp - trial) : rp;
        sq_q <= {sq_q[29:0], sq_ge};
        sr <= {sr[59:0], 2'b00};
      end
      OP_SQRT_FIN: root <= (sq_r > 35'(sq_q)) ? (32'(sq_q) + 32'd1) : 32'(sq_q);
      OP_MEAN_PREP: begin
        nq <= nsum[64:20];
        if (qzero) begin
          status_r <= ST_ZERO_QUAT;
        end else if (count < CNT_W'(3)) begin
          status_r <= ST_FEW_PAIRS;
        end else if (count > CNT_W'(MAX_PAIRS)) begin
          status_r <= ST_TOO_MANY;
        end else begin
          status_r <= ST_OK;
        end
      end
      OP_DIV_LOAD_MEAN: begin
        sat <= nq[44:32] >= {2'b00, count};
        drem <= 34'(nq[44:32]);
        dq <= nq[31:0];
        ddiv <= 33'(count);
      end
      OP_OUT_LOAD: begin
        result_word.status <= status_r;
        if (status_r != ST_OK) begin
          result_word.mean_error <= '0;
        end else if (sat) begin
          result_word.mean_error <= '1;
        end else begin
          result_word.mean_error <= dq;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.count_zero = (count == '0);
  assign stat.accum_ok = (count < CNT_W'(MAX_PAIRS));
  assign stat.last = pw.last_pair;
  assign stat.n_zero = (n_val == 36'sd0);
  assign stat.out_free = !result_valid || !result_stall;

endmodule

[hdl/rfwe_ctrl.sv]
// ----------------------------------------------------------------------------
// rfwe_ctrl
// Sequencer that steps the datapath through transform latch, per-pair
// distance, accumulation and the final mean.
// ----------------------------------------------------------------------------
module rfwe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  rfwe_pkg::dp_stat_t stat,
  output rfwe_pkg::dp_cmd_t  cmd
);
  import rfwe_pkg::*;

  ctrl_state_t state, state_next;
  logic [3:0]  idx, idx_next;
  logic [1:0]  row, row_next;
  logic [1:0]  col, col_next;
  logic [5:0]  iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      row <= '0;
      col <= '0;
      iter <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      row <= row_next;
      col <= col_next;
      iter <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    row_next = row;
    col_next = col;
    iter_next = iter;
    cmd.op = OP_NONE;
    cmd.idx = idx;
    cmd.row = row;
    cmd.col = col;
    pair_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        idx_next = '0;
        row_next = '0;
        col_next = '0;
        if (pair_valid) begin
          cmd.op = OP_CAPTURE;
          if (stat.count_zero) begin
            state_next = S_QMUL;
          end else if (stat.accum_ok) begin
            state_next = S_ROW_INIT;
          end else begin
            state_next = S_COUNT;
          end
        end
      end
      S_QMUL: begin
        cmd.op = OP_QMUL;
        state_next = S_QSTORE;
      end
      S_QSTORE: begin
        cmd.op = OP_QSTORE;
        if (idx == 4'(NUM_QP - 1)) begin
          idx_next = '0;
          state_next = S_LATCH;
        end else begin
          idx_next = idx + 1'b1;
          state_next = S_QMUL;
        end
      end
      S_LATCH: begin
        cmd.op = OP_LATCH;
        state_next = stat.n_zero ? S_MCLEAR : S_DLOAD;
      end
      S_MCLEAR: begin
        cmd.op = OP_MCLEAR;
        state_next = S_ROW_INIT;
      end
      S_DLOAD: begin
        cmd.op = OP_DIV_LOAD_M;
        iter_next = '0;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DIV_STEP;
        iter_next = iter + 1'b1;
        if (iter == 6'(DIV_M_STEPS - 1)) begin
          state_next = S_MSTORE;
        end
      end
      S_MSTORE: begin
        cmd.op = OP_MSTORE;
        if (idx == 4'(NUM_MAT - 1)) begin
          idx_next = '0;
          state_next = S_ROW_INIT;
        end else begin
          idx_next = idx + 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_ROW_INIT: begin
        cmd.op = OP_ROW_INIT;
        col_next = '0;
        state_next = S_MV_MUL;
      end
      S_MV_MUL: begin
        cmd.op = OP_MV_MUL;
        cmd.idx = 4'(row) * 4'd3 + 4'(col);
        state_next = S_MV_ACC;
      end
      S_MV_ACC: begin
        cmd.op = OP_MV_ACC;
        if (col == 2'd2) begin
          col_next = '0;
          state_next = S_RND;
        end else begin
          col_next = col + 1'b1;
          state_next = S_MV_MUL;
        end
      end
      S_RND: begin
        cmd.op = OP_RND;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        state_next = S_SS;
      end
      S_SS: begin
        cmd.op = OP_SS;
        if (row == 2'd2) begin
          row_next = '0;
          state_next = S_SQRT_LOAD;
        end else begin
          row_next = row + 1'b1;
          state_next = S_ROW_INIT;
        end
      end
      S_SQRT_LOAD: begin
        cmd.op = OP_SQRT_LOAD;
        iter_next = '0;
        state_next = S_SQRT_STEP;
      end
      S_SQRT_STEP: begin
        cmd.op = OP_SQRT_STEP;
        iter_next = iter + 1'b1;
        if (iter == 6'(SQRT_STEPS - 1)) begin
          state_next = S_SQRT_FIN;
        end
      end
      S_SQRT_FIN: begin
        cmd.op = OP_SQRT_FIN;
        state_next = S_WMUL;
      end
      S_WMUL: begin
        cmd.op = OP_WMUL;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.op = OP_ACCUM;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.op = OP_COUNT;
        state_next = stat.last ? S_MEAN_PREP : S_IDLE;
      end
      S_MEAN_PREP: begin
        cmd.op = OP_MEAN_PREP;
        state_next = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.op = OP_DIV_LOAD_MEAN;
        iter_next = '0;
        state_next = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.op = OP_DIV_STEP;
        iter_next = iter + 1'b1;
        if (iter == 6'(DIV_MEAN_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[tb/tb_rigid_fit_weighted_error.sv]
// ----------------------------------------------------------------------------
// tb_rigid_fit_weighted_error
// Self-checking bench for the rigid fit weighted error block. Pose registers
// are written between point sets; pair words are streamed in bursts while the
// result side stalls on its own pattern. A bit-exact predictor forms each
// expected mean and status word, and a scoreboard checks every result word.
// ----------------------------------------------------------------------------
module tb_rigid_fit_weighted_error;
  timeunit 1ns;
  timeprecision 1ps;
  import rfwe_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  // Predictor of the block plus the store of expected result words.
  class fit_scoreboard;
    int           pose [NUM_REGS];
    int           rot [NUM_MAT];
    int           shift [3];
    bit [63:0]    dist_sum;
    int           pairs;
    bit           quat_null;
    result_word_t means_due [$];
    int           errors;
    int           results_seen;

    function new();
      foreach (pose[i]) pose[i] = REG_RESET[i];
      dist_sum = 0;
      pairs = 0;
      quat_null = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx < NUM_REGS) pose[idx] = val;
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Round half away from zero, dropping k fraction bits.
    function longint round_off(longint v, int k);
      bit [63:0] m;
      m = (mag(v) + (64'd1 << (k - 1))) >> k;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Integer square root, rounded to nearest with ties going up.
    function bit [63:0] root_nearest(bit [63:0] s);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return s > r ? r + 1 : r;
    endfunction

    function void latch_pose();
      longint a, b, c, d, n;
      longint m [NUM_MAT];
      bit [63:0] q;
      a = pose[0] - 32768;
      b = pose[1] - 32768;
      c = pose[2] - 32768;
      d = pose[3] - 32768;
      n = a * a + b * b + c * c + d * d;
      m[0] = a * a + b * b - c * c - d * d;
      m[1] = 2 * (b * c - a * d);
      m[2] = 2 * (b * d + a * c);
      m[3] = 2 * (b * c + a * d);
      m[4] = a * a - b * b + c * c - d * d;
      m[5] = 2 * (c * d - a * b);
      m[6] = 2 * (b * d - a * c);
      m[7] = 2 * (c * d + a * b);
      m[8] = a * a - b * b - c * c + d * d;
      quat_null = (n == 0);
      for (int i = 0; i < NUM_MAT; i++) begin
        if (n == 0) begin
          rot[i] = 0;
        end else begin
          q = ((mag(m[i]) << 30) + 64'(n) / 2) / 64'(n);
          rot[i] = m[i] < 0 ? -int'(q) : int'(q);
        end
      end
      for (int i = 0; i < 3; i++) shift[i] = (pose[4 + i] - 32768) * 40;
    endfunction

    function void note_pair(pair_word_t w);
      longint mv [3];
      longint rf [3];
      longint acc;
      bit [63:0] ss, dm, den, mean;
      result_word_t r;
      mv[0] = longint'(w.moved_x);
      mv[1] = longint'(w.moved_y);
      mv[2] = longint'(w.moved_z);
      rf[0] = longint'(w.ref_x);
      rf[1] = longint'(w.ref_y);
      rf[2] = longint'(w.ref_z);
      if (pairs == 0) latch_pose();
      if (pairs < MAX_PAIRS) begin
        ss = 0;
        for (int i = 0; i < 3; i++) begin
          acc = longint'(rot[3 * i]) * mv[0] + longint'(rot[3 * i + 1]) * mv[1]
              + longint'(rot[3 * i + 2]) * mv[2];
          acc = acc + longint'(shift[i]) * 64'sd4194304;
          acc = acc - rf[i] * 64'sd1073741824;
          dm = mag(round_off(acc, 26));
          ss = ss + dm * dm;
        end
        dist_sum = dist_sum + root_nearest(ss) * 64'(w.weight);
      end
      if (pairs <= MAX_PAIRS) pairs++;
      if (!w.last_pair) return;
      r.mean_error = 0;
      if (quat_null) r.status = ST_ZERO_QUAT;
      else if (pairs < 3) r.status = ST_FEW_PAIRS;
      else if (pairs > MAX_PAIRS) r.status = ST_TOO_MANY;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        den = 64'(pairs) << 20;
        mean = (dist_sum + den / 2) / den;
        r.mean_error = mean > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : mean[31:0];
      end
      means_due = {means_due, r};
      dist_sum = 0;
      pairs = 0;
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      results_seen++;
      if (means_due.size() == 0) begin
        $error("unexpected result word: mean_error %0d status %0d",
               got.mean_error, got.status);
        errors++;
        return;
      end
      want = means_due.pop_front();
      if (got.mean_error !== want.mean_error) begin
        $error("mean_error: expected %0d, got %0d", want.mean_error, got.mean_error);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         pair_valid;
  logic         pair_stall;
  pair_word_t   pair_word;
  logic         result_valid;
  logic         result_stall;
  result_word_t result_word;
  logic         cfg_write;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  fit_scoreboard sb;
  int cycles;
  int burst_left;
  int hold_left;
  int stall_mode;
  int sets_sent;
  int pairs_sent;

  rigid_fit_weighted_error dut (
    .clk         (clk),
    .rst         (rst),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .pair_word   (pair_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word (result_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: every accepted word, in either direction, and every register
  // write is handed to the scoreboard at the clock edge that takes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (pair_valid && !pair_stall) sb.note_pair(pair_word);
      if (result_valid && !result_stall) sb.check_result(result_word);
    end
  end

  // Receiver. A requested hold-off is counted down here; otherwise the stall
  // pattern drifts between never, now and then, and half the time.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          result_stall <= 1'b0;
        end
        1: begin
          result_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_stall <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  function automatic pair_word_t make_pair(bit last, bit narrow);
    pair_word_t w;
    w.ref_x = 24'($urandom);
    w.ref_y = 24'($urandom);
    w.ref_z = 24'($urandom);
    w.moved_x = 24'($urandom);
    w.moved_y = 24'($urandom);
    w.moved_z = 24'($urandom);
    w.weight = 16'($urandom);
    // Narrow pairs keep the points near each other so the mean stays small
    // and the rounding of the low bits is exercised.
    if (narrow) begin
      w.ref_x = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      w.ref_y = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      w.ref_z = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      w.moved_x = w.ref_x + $signed(24'($urandom_range(0, 255))) - 24'sd128;
      w.moved_y = w.ref_y + $signed(24'($urandom_range(0, 255))) - 24'sd128;
      w.moved_z = w.ref_z + $signed(24'($urandom_range(0, 255))) - 24'sd128;
    end
    w.last_pair = last;
    return w;
  endfunction

  // Offers one word and returns at the edge that accepts it. Between bursts
  // valid may drop for a random gap.
  task automatic send_pair(pair_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (pair_valid && $urandom_range(0, 3) != 0) begin
        pair_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    burst_left--;
    pair_valid <= 1'b1;
    pair_word <= w;
    do @(posedge clk); while (pair_stall);
    pairs_sent++;
  endtask

  task automatic send_set(int n, bit narrow);
    for (int i = 1; i <= n; i++) send_pair(make_pair(i == n, narrow));
    sets_sent++;
  endtask

  // Lets the block go quiet: all results in, then the last word's tail.
  task automatic settle();
    pair_valid <= 1'b0;
    do @(posedge clk); while (sb.means_due.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_pose();
    for (int i = 0; i < NUM_REGS; i++) begin
      case ($urandom_range(0, 5))
        0: write_reg(3'(i), 16'h0000);
        1: write_reg(3'(i), 16'hFFFF);
        2: write_reg(3'(i), 16'h8000);
        default: write_reg(3'(i), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    pair_pose_init: begin
      clk = 1'b0;
      rst = 1'b1;
      pair_valid = 1'b0;
      pair_word = '0;
      cfg_write = 1'b0;
      cfg_index = '0;
      cfg_data = '0;
      cycles = 0;
      burst_left = 0;
      hold_left = 0;
      stall_mode = 0;
      sets_sent = 0;
      pairs_sent = 0;
    end
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset pose (identity, no shift) with extreme coordinates and
    // weights, then a run with only one pair and one with two.
    begin
      pair_word_t w;
      w = make_pair(1'b0, 1'b0);
      w.ref_x = 24'sh7FFFFF; w.ref_y = -24'sh800000; w.ref_z = '0;
      w.moved_x = -24'sh800000; w.moved_y = 24'sh7FFFFF; w.moved_z = '0;
      w.weight = 16'hFFFF;
      send_pair(w);
      w.weight = 16'h0000;
      send_pair(w);
      w = make_pair(1'b1, 1'b1);
      w.weight = 16'hFFFF;
      send_pair(w);
    end
    send_set(1, 1'b1);
    send_set(2, 1'b0);
    settle();

    // Zero quaternion: all four quaternion registers at mid-scale.
    write_reg(REG_QA, 16'h8000);
    send_set(4, 1'b0);
    settle();

    // Registers at their extremes, and a write to the unused index, which
    // must leave the pose alone.
    write_reg(REG_QA, 16'h0000);
    write_reg(REG_QB, 16'hFFFF);
    write_reg(REG_QC, 16'h0000);
    write_reg(REG_QD, 16'hFFFF);
    write_reg(REG_SX, 16'h0000);
    write_reg(REG_SY, 16'hFFFF);
    write_reg(REG_SZ, 16'h0000);
    write_reg(3'd7, 16'h1234);
    send_set(3, 1'b1);
    send_set(5, 1'b0);
    settle();

    // A run beyond the pair limit.
    random_pose();
    write_reg(REG_QA, 16'hC000);
    send_set(MAX_PAIRS + 2, 1'b1);
    settle();

    // Back pressure: the receiver holds off while short sets keep coming,
    // so the result register fills and the input side stalls.
    random_pose();
    write_reg(REG_QB, 16'h2000);
    hold_left = 3000;
    for (int k = 0; k < 6; k++) send_set(3, 1'($urandom_range(0, 1)));
    settle();

    // Random part: mostly well-formed sets of normal size, some short ones,
    // with a fresh pose between groups.
    while (pairs_sent < 1200) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        random_pose();
      end
      case ($urandom_range(0, 9))
        0: send_set($urandom_range(1, 2), 1'($urandom_range(0, 1)));
        1: send_set($urandom_range(20, 40), 1'($urandom_range(0, 1)));
        default: send_set($urandom_range(3, 10), 1'($urandom_range(0, 1)));
      endcase
    end
    settle();

    $display("Covered %0d pair words in %0d sets, %0d result words checked.",
             pairs_sent, sets_sent, sb.results_seen);
    $display("Poses included identity, zero quaternion and register extremes.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
